// ===== rtl/assert_macros.svh =====
// Assertion macros used by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/afr_pkg.sv =====
// Types, constants and codes of the addressed frame receiver.
`default_nettype none
package afr_pkg;
	localparam int MAX_FRAME_BYTES = 21;
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

	localparam int BYTE_W     = 8;
	localparam int ACTION_W   = 2;
	localparam int READ_IDX_W = 5;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 2;

	localparam int SHORT_LEN = 5;
	localparam int LONG_LEN  = 21;

	localparam logic [BYTE_W-1:0] CMD_READ_RUN   = 8'hA1;
	localparam logic [BYTE_W-1:0] CMD_READ_PARAM = 8'hA2;
	localparam logic [BYTE_W-1:0] CMD_SAVE_PARAM = 8'hA3;
	localparam logic [BYTE_W-1:0] CMD_MANUAL_CHG = 8'hA4;
	localparam logic [BYTE_W-1:0] CMD_MANUAL_DIS = 8'hA5;
	localparam logic [BYTE_W-1:0] CMD_AUTO       = 8'hA6;
	localparam logic [BYTE_W-1:0] FRAME_END      = 8'hAA;
	localparam logic [BYTE_W-1:0] TIMEOUT_RESET  = 8'h0A;

	localparam logic [KIND_W-1:0] KIND_REJECT      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_READ_RUN    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ_PARAM  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SAVE_PARAM  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MANUAL_CHG  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_MANUAL_DIS  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_AUTO        = 3'd6;

	localparam logic RES_DECISION = 1'b0;
	localparam logic RES_READ     = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_BYTE    = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef struct packed {
		action_t                 action;
		logic [BYTE_W-1:0]       rx_byte;
		logic [READ_IDX_W-1:0]   read_index;
	} item_t;

	typedef struct packed {
		logic                result_type;
		logic [KIND_W-1:0]   frame_kind;
		logic [BYTE_W-1:0]   read_data;
	} result_t;

	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    addr;
		logic [BYTE_W-1:0]   data;
	} buf_wr_t;

	typedef struct packed {
		logic [BYTE_W-1:0] addr_byte;
		logic [BYTE_W-1:0] cmd_byte;
		logic [BYTE_W-1:0] short_end;
		logic [BYTE_W-1:0] long_end;
	} buf_taps_t;
endpackage
`default_nettype wire

// ===== rtl/afr_item_if.sv =====
// Input item channel of the receiver.
`default_nettype none
interface afr_item_if;
	logic                             valid;
	logic                             ready;
	logic [afr_pkg::ACTION_W-1:0]     action;
	logic [afr_pkg::BYTE_W-1:0]       rx_byte;
	logic [afr_pkg::READ_IDX_W-1:0]   read_index;

	modport source (output valid, output action, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input action, input rx_byte, input read_index,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/afr_result_if.sv =====
// Result item channel of the receiver.
`default_nettype none
interface afr_result_if;
	logic                          valid;
	logic                          ready;
	logic                          result_type;
	logic [afr_pkg::KIND_W-1:0]    frame_kind;
	logic [afr_pkg::BYTE_W-1:0]    read_data;

	modport source (output valid, output result_type, output frame_kind,
		output read_data, input ready);
	modport sink (input valid, input result_type, input frame_kind,
		input read_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/afr_cfg_if.sv =====
// Configuration write channel of the receiver.
`default_nettype none
interface afr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [afr_pkg::CFG_IDX_W-1:0]   index;
	logic [afr_pkg::BYTE_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/addressed_frame_receiver_core.sv =====
// Top level of the addressed frame receiver.
// Path: an item is registered, then its result (if any) is registered.
// Throughput: one item per cycle unless a waiting result stalls an item that has a result; the output
// register lets an item without a result move on while a result waits to be taken.
// Reset (arst_n low, asynchronous): pipeline empty, count, timer and hold cleared,
// station address 0, idle timeout 10 ticks; buffer contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module addressed_frame_receiver_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	afr_item_if.sink        item,
	afr_result_if.source    result,
	afr_cfg_if.sink         cfg
);
	logic                         valid_s1;
	afr_pkg::item_t               item_s1;
	logic                         valid_s2;
	afr_pkg::result_t             res_s2;
	logic [afr_pkg::BYTE_W-1:0]   station_addr_q;
	logic [afr_pkg::BYTE_W-1:0]   idle_timeout_q;
	logic                         fire;
	logic                         has_result;
	afr_pkg::result_t             res;
	afr_pkg::buf_wr_t             wr;
	afr_pkg::buf_taps_t           taps;
	logic [afr_pkg::BYTE_W-1:0]   rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_addr_q <= '0;
			idle_timeout_q <= afr_pkg::TIMEOUT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == afr_pkg::REG_STATION_ADDR) begin
				station_addr_q <= cfg.data;
			end else if (cfg.index == afr_pkg::REG_IDLE_TIMEOUT) begin
				idle_timeout_q <= cfg.data;
			end
		end
	end

	assign fire = valid_s1 && (!has_result || !valid_s2 || result.ready);
	assign item.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.action     <= afr_pkg::action_t'(item.action);
			item_s1.rx_byte    <= item.rx_byte;
			item_s1.read_index <= item.read_index;
		end
	end

	afr_buf u_buf (
		.clk        (clk),
		.wr         (wr),
		.read_index (item_s1.read_index),
		.taps       (taps),
		.rd_data    (rd_data)
	);

	afr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.item_s1      (item_s1),
		.station_addr (station_addr_q),
		.idle_timeout (idle_timeout_q),
		.taps         (taps),
		.rd_data      (rd_data),
		.wr           (wr),
		.has_result   (has_result),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && has_result) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			res_s2 <= res;
		end
	end

	assign result.valid       = valid_s2;
	assign result.result_type = res_s2.result_type;
	assign result.frame_kind  = res_s2.frame_kind;
	assign result.read_data   = res_s2.read_data;

	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, valid_s2 && !result.ready, !(fire && has_result))
	`ASSERT_NEXT(a_new_result_needs_item, clk, arst_n, valid_s2 && result.ready, !valid_s2 || $past(fire))
	`ASSERT_IMPLY(a_decision_no_data, clk, arst_n, valid_s2 && res_s2.result_type == afr_pkg::RES_DECISION, res_s2.read_data == '0)
endmodule
`default_nettype wire

// ===== rtl/afr_buf.sv =====
// Frame byte buffer: one write port, fixed taps and one indexed read.
`default_nettype none
module afr_buf (
	input  wire logic                              clk,
	input  wire afr_pkg::buf_wr_t                  wr,
	input  wire logic [afr_pkg::READ_IDX_W-1:0]    read_index,
	output afr_pkg::buf_taps_t                     taps,
	output logic [afr_pkg::BYTE_W-1:0]             rd_data
);
	logic [afr_pkg::BYTE_W-1:0] bytes_q [afr_pkg::MAX_FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			bytes_q[wr.addr] <= wr.data;
		end
	end

	always_comb begin
		taps.addr_byte = bytes_q[0];
		taps.cmd_byte  = bytes_q[1];
		taps.short_end = bytes_q[afr_pkg::SHORT_LEN-1];
		taps.long_end  = bytes_q[afr_pkg::LONG_LEN-1];
	end

	always_comb begin
		if (int'(read_index) < afr_pkg::MAX_FRAME_BYTES) begin
			rd_data = bytes_q[read_index[afr_pkg::IDX_W-1:0]];
		end else begin
			rd_data = '0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/afr_ctrl.sv =====
// Frame state: byte count, idle timer, hold flag and frame classification.
`default_nettype none
module afr_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire afr_pkg::item_t                item_s1,
	input  wire logic [afr_pkg::BYTE_W-1:0]    station_addr,
	input  wire logic [afr_pkg::BYTE_W-1:0]    idle_timeout,
	input  wire afr_pkg::buf_taps_t            taps,
	input  wire logic [afr_pkg::BYTE_W-1:0]    rd_data,
	output afr_pkg::buf_wr_t                   wr,
	output logic                               has_result,
	output afr_pkg::result_t                   res
);
	logic [afr_pkg::CNT_W-1:0]   count_q;
	logic [afr_pkg::BYTE_W-1:0]  timer_q;
	logic                        held_q;
	logic                        room;
	logic                        addr_match;
	logic                        timeout_hit;
	logic [afr_pkg::KIND_W-1:0]  kind;

	assign room = (count_q < afr_pkg::CNT_W'(afr_pkg::MAX_FRAME_BYTES)) && !held_q;
	assign addr_match = (count_q == '0) ? (item_s1.rx_byte == station_addr)
		: (taps.addr_byte == station_addr);
	assign timeout_hit = (timer_q == afr_pkg::BYTE_W'(1));

	always_comb begin
		kind = afr_pkg::KIND_REJECT;
		if (count_q == afr_pkg::CNT_W'(afr_pkg::SHORT_LEN)
				&& taps.short_end == afr_pkg::FRAME_END) begin
			priority if (taps.cmd_byte == afr_pkg::CMD_READ_RUN) begin
				kind = afr_pkg::KIND_READ_RUN;
			end else if (taps.cmd_byte == afr_pkg::CMD_READ_PARAM) begin
				kind = afr_pkg::KIND_READ_PARAM;
			end else if (taps.cmd_byte == afr_pkg::CMD_MANUAL_CHG) begin
				kind = afr_pkg::KIND_MANUAL_CHG;
			end else if (taps.cmd_byte == afr_pkg::CMD_MANUAL_DIS) begin
				kind = afr_pkg::KIND_MANUAL_DIS;
			end else if (taps.cmd_byte == afr_pkg::CMD_AUTO) begin
				kind = afr_pkg::KIND_AUTO;
			end else begin
				kind = afr_pkg::KIND_REJECT;
			end
		end else if (count_q == afr_pkg::CNT_W'(afr_pkg::LONG_LEN)
				&& taps.cmd_byte == afr_pkg::CMD_SAVE_PARAM
				&& taps.long_end == afr_pkg::FRAME_END) begin
			kind = afr_pkg::KIND_SAVE_PARAM;
		end
	end

	always_comb begin
		wr.en   = fire && item_s1.action == afr_pkg::ACT_BYTE && room;
		wr.addr = count_q[afr_pkg::IDX_W-1:0];
		wr.data = item_s1.rx_byte;
	end

	always_comb begin
		has_result = (item_s1.action == afr_pkg::ACT_READ)
			|| (item_s1.action == afr_pkg::ACT_TICK && timeout_hit);
		if (item_s1.action == afr_pkg::ACT_READ) begin
			res.result_type = afr_pkg::RES_READ;
			res.frame_kind  = afr_pkg::KIND_REJECT;
			res.read_data   = rd_data;
		end else begin
			res.result_type = afr_pkg::RES_DECISION;
			res.frame_kind  = kind;
			res.read_data   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			timer_q <= '0;
			held_q  <= 1'b0;
		end else if (fire) begin
			unique case (item_s1.action)
				afr_pkg::ACT_BYTE: begin
					timer_q <= idle_timeout;
					if (room && addr_match) begin
						count_q <= count_q + afr_pkg::CNT_W'(1);
					end
				end
				afr_pkg::ACT_TICK: begin
					if (timer_q != '0) begin
						timer_q <= timer_q - afr_pkg::BYTE_W'(1);
					end
					if (timeout_hit) begin
						if (kind != afr_pkg::KIND_REJECT) begin
							held_q <= 1'b1;
						end else begin
							count_q <= '0;
						end
					end
				end
				afr_pkg::ACT_RELEASE: begin
					held_q  <= 1'b0;
					count_q <= '0;
				end
				afr_pkg::ACT_READ: begin
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire
